/* hw/rtl/brmh_pkg.sv */
// ----------------------------------------------------------------------------
// brmh_pkg
// Shared constants, types and helper functions of the byte stream hash.
// ----------------------------------------------------------------------------
package brmh_pkg;

  localparam int MAX_WORDS = 16;
  localparam int IDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int ADDR_W    = 4;

  localparam logic [31:0] GOLDEN     = 32'h9E3779B1;
  localparam logic [31:0] AVAL_A     = 32'h85EBCA6B;
  localparam logic [31:0] AVAL_B     = 32'hC2B2AE35;
  localparam logic [31:0] SEED_RESET = 32'h1F2E3D4C;

  localparam logic [1:0] OP_FEED        = 2'd0;
  localparam logic [1:0] OP_FEED_FINISH = 2'd1;

  localparam logic [1:0] REG_WORD_BYTES  = 2'd0;
  localparam logic [1:0] REG_STATE_WORDS = 2'd1;
  localparam logic [1:0] REG_SEED        = 2'd2;

  // Request from the sequencer to the state memory.
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             clear;
  } mem_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] t;
    t = {v, v} << r;
    return t[63:32];
  endfunction

  function automatic logic [4:0] rot_amt(input logic [2:0] idx);
    logic [4:0] a;
    case (idx)
      3'd0: a = 5'd5;
      3'd1: a = 5'd7;
      3'd2: a = 5'd9;
      3'd3: a = 5'd11;
      3'd4: a = 5'd13;
      3'd5: a = 5'd17;
      3'd6: a = 5'd19;
      3'd7: a = 5'd23;
      default: a = 5'd5;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/brmh_in_if.sv */
// ----------------------------------------------------------------------------
// brmh_in_if
// Input channel: one message byte word with its operation code.
// ----------------------------------------------------------------------------
interface brmh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

/* hw/rtl/brmh_out_if.sv */
// ----------------------------------------------------------------------------
// brmh_out_if
// Output channel: one finished 32-bit hash word.
// ----------------------------------------------------------------------------
interface brmh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

/* hw/rtl/brmh_state_ram.sv */
// ----------------------------------------------------------------------------
// brmh_state_ram
// State word memory with one write and one registered read port. Per-entry
// valid bits make a cleared entry read back as its seeded value.
// ----------------------------------------------------------------------------
module brmh_state_ram import brmh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] seed,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0]          mem [MAX_WORDS];
  logic [MAX_WORDS-1:0] valid;
  logic [31:0]          rdata_q;
  logic [31:0]          rinit_q;
  logic                 rvalid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rdata_q <= mem[req.rd_addr];
    rinit_q <= seed ^ 32'(32'(req.rd_addr) * GOLDEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid[req.rd_addr];
      if (req.clear) begin
        valid <= '0;
      end else if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rvalid_q ? rdata_q : rinit_q;

endmodule

/* hw/rtl/byte_stream_rotate_mix_hash.sv */
// ----------------------------------------------------------------------------
// byte_stream_rotate_mix_hash
// Byte stream hash: packs bytes into words, mixes each word into a state
// file held in a memory, then folds and finishes the state into a hash.
// ----------------------------------------------------------------------------
// A byte that does not complete a word is only packed into the assembly
// word. A byte that completes a word (or a finish with a partial word) starts
// a mix that streams the N active state words through the single memory
// read port; after the read pass the states S_MIX_ADD, S_MIX_XOR, S_MIX_MUL
// and S_MIX_WB cover the add, the two golden-ratio multiplies and the
// write-back of word 0. A finish then runs the fold, after the mix or at once
// for an empty message: the same read pass and the two avalanche multiplies.
// The hash word waits in an output register; the next message is accepted
// while it waits, and a second hash stalls until the first is taken.
// Reloading from the seed is done by clearing the per-entry valid bits.
module byte_stream_rotate_mix_hash import brmh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  brmh_in_if.sink           msg,
  brmh_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_MIX, S_MIX_ADD, S_MIX_XOR, S_MIX_MUL, S_MIX_WB,
    S_FOLD, S_FOLD_M1, S_FOLD_M2, S_FOLD_OUT
  } state_t;

  state_t           state;
  logic [2:0]       word_bytes;
  logic [4:0]       state_words;
  logic [31:0]      seed;
  logic [31:0]      asm_word;
  logic [2:0]       bytes_held;
  logic [31:0]      mix_word;
  logic             do_fold;
  logic [CNT_W-1:0] rd_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [31:0]      acc;
  logic [31:0]      w0;
  logic [31:0]      prev;
  logic [31:0]      pg;
  logic             out_valid;
  logic [31:0]      out_hash;

  logic [2:0]       width_eff;
  logic [CNT_W-1:0] n_words;
  logic             accept, feed, finish, full, start_mix;
  logic [31:0]      asm_n, padded, mix_word_n;
  logic [2:0]       held_n, pad;
  logic             issue, last, out_free;
  logic [31:0]      rd_data, rot_x, rot_s, mix_xor;
  logic [31:0]      x1, x2, x3;
  logic [4:0]       rot_x_amt;
  logic [1:0]       cfg_idx;
  logic             cfg_we;
  mem_req_t         mem_req;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite &&
                   (cfg_idx inside {REG_WORD_BYTES, REG_STATE_WORDS, REG_SEED});

  always_comb begin
    case (cfg_idx)
      REG_WORD_BYTES:  prdata = {29'd0, word_bytes};
      REG_STATE_WORDS: prdata = {27'd0, state_words};
      REG_SEED:        prdata = seed;
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    width_eff = (word_bytes inside {3'd1, 3'd2, 3'd4}) ? word_bytes : 3'd4;
    if (state_words < 5'd2) begin
      n_words = CNT_W'(2);
    end else if (32'(state_words) > MAX_WORDS) begin
      n_words = CNT_W'(MAX_WORDS);
    end else begin
      n_words = CNT_W'(state_words);
    end
  end

  // Byte packing decision for the word on the input.
  assign accept     = msg.valid && msg.ready;
  assign feed       = (msg.op == OP_FEED) || (msg.op == OP_FEED_FINISH);
  assign finish     = (msg.op != OP_FEED);
  assign asm_n      = feed ? {asm_word[23:0], msg.data_byte} : asm_word;
  assign held_n     = feed ? bytes_held + 3'd1 : bytes_held;
  assign full       = feed && (held_n >= width_eff);
  assign pad        = width_eff - held_n;
  assign padded     = asm_n << {pad, 3'b000};
  assign start_mix  = full || (finish && (held_n != 3'd0));
  assign mix_word_n = full ? asm_n : padded;

  // Read pass bookkeeping; read data arrives in the cycle after its address.
  assign issue = (rd_idx < n_words);
  assign last  = ((CNT_W'(pend_idx) + CNT_W'(1)) == n_words);

  // Word 1 enters the mix with its own fixed rotation.
  assign rot_x_amt = (pend_idx == IDX_W'(1)) ? 5'd13 : rot_amt(3'(pend_idx));
  assign rot_x     = rotl(rd_data, rot_x_amt);
  assign rot_s     = rotl(rd_data, 5'(32'(pend_idx) + 32'd5));

  assign x1      = acc ^ pg ^ mix_word;
  assign x2      = x1 + rotl(mix_word, 5'd19);
  assign x3      = x2 ^ rotl(mix_word, 5'd23);
  assign mix_xor = x3 ^ rotl(x3, 5'd9);

  assign out_free = !out_valid || result.ready;

  always_comb begin
    mem_req.rd_addr = (state == S_IDLE) ? '0 : rd_idx[IDX_W-1:0];
    mem_req.wr_en   = ((state == S_MIX) && pend && (pend_idx != '0)) ||
                      (state == S_MIX_WB);
    if (state == S_MIX_WB) begin
      mem_req.wr_addr = '0;
      mem_req.wr_data = acc ^ (acc >> 15);
    end else begin
      mem_req.wr_addr = pend_idx;
      mem_req.wr_data = rot_s ^ prev ^ (last ? mix_word : 32'd0);
    end
    mem_req.clear = cfg_we || ((state == S_FOLD_OUT) && out_free);
  end

  brmh_state_ram u_state_ram (
    .clk     (clk),
    .rst     (rst),
    .seed    (seed),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign msg.ready         = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.hash_value = out_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      word_bytes  <= 3'd4;
      state_words <= 5'd4;
      seed        <= SEED_RESET;
      asm_word    <= 32'd0;
      bytes_held  <= 3'd0;
      do_fold     <= 1'b0;
      rd_idx      <= '0;
      pend        <= 1'b0;
      pend_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      // A new hash word loaded in S_FOLD_OUT takes the place of the old one.
      if (result.ready && !((state == S_FOLD_OUT) && out_free)) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx)
          REG_WORD_BYTES:  word_bytes  <= pwdata[2:0];
          REG_STATE_WORDS: state_words <= pwdata[4:0];
          REG_SEED:        seed        <= pwdata;
          default:         seed        <= seed;
        endcase
        asm_word   <= 32'd0;
        bytes_held <= 3'd0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (full || finish) begin
              asm_word   <= 32'd0;
              bytes_held <= 3'd0;
            end else begin
              asm_word   <= asm_n;
              bytes_held <= held_n;
            end
            mix_word <= mix_word_n;
            do_fold  <= finish;
            // Word 0 was read in this cycle, so the pass starts at word 1.
            pend     <= 1'b1;
            pend_idx <= '0;
            rd_idx   <= CNT_W'(1);
            if (start_mix) begin
              state <= S_MIX;
            end else if (finish) begin
              state <= S_FOLD;
            end
          end
        end

        S_MIX: begin
          if (issue) begin
            rd_idx   <= rd_idx + CNT_W'(1);
            pend_idx <= rd_idx[IDX_W-1:0];
          end
          pend <= issue;
          if (pend) begin
            if (pend_idx == '0) begin
              w0  <= rd_data;
              acc <= rd_data;
            end else begin
              acc <= acc ^ rot_x ^
                     ((pend_idx == IDX_W'(1)) ? (mix_word & rd_data) : 32'd0);
            end
            prev <= rd_data;
            if (last) begin
              state <= S_MIX_ADD;
            end
          end
        end

        S_MIX_ADD: begin
          acc   <= acc + rotl(w0, 5'd17);
          pg    <= mix_word * GOLDEN;
          state <= S_MIX_XOR;
        end

        S_MIX_XOR: begin
          acc   <= mix_xor;
          state <= S_MIX_MUL;
        end

        S_MIX_MUL: begin
          acc   <= acc * GOLDEN;
          state <= S_MIX_WB;
        end

        S_MIX_WB: begin
          // Word 0 is written now, so the fold pass issues its own first read.
          rd_idx <= '0;
          pend   <= 1'b0;
          state  <= do_fold ? S_FOLD : S_IDLE;
        end

        S_FOLD: begin
          if (issue) begin
            rd_idx   <= rd_idx + CNT_W'(1);
            pend_idx <= rd_idx[IDX_W-1:0];
          end
          pend <= issue;
          if (pend) begin
            acc <= (pend_idx == '0) ? rd_data : (acc ^ rot_s);
            if (last) begin
              state <= S_FOLD_M1;
            end
          end
        end

        S_FOLD_M1: begin
          acc   <= (acc ^ (acc >> 16)) * AVAL_A;
          state <= S_FOLD_M2;
        end

        S_FOLD_M2: begin
          acc   <= (acc ^ (acc >> 13)) * AVAL_B;
          state <= S_FOLD_OUT;
        end

        S_FOLD_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_hash  <= acc ^ (acc >> 16);
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/brmh_checker.sv */
// ----------------------------------------------------------------------------
// brmh_checker
// Port-level checks of the byte stream hash, bound to the top level.
// ----------------------------------------------------------------------------
module brmh_checker import brmh_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash
);

  // After reset the block is ready for a word and holds no hash.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hash)))
    else $error("stalled hash word changed");

  // A plain feed word never produces a hash.
  a_feed_no_hash: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_op == OP_FEED) && !out_valid) |=> !out_valid)
    else $error("hash appeared after a feed word");

  // A finish always runs the fold, so input stalls in the next cycle.
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_op != OP_FEED)) |=> !in_ready)
    else $error("input ready right after a finish");

endmodule

bind byte_stream_rotate_mix_hash brmh_checker u_brmh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_op     (msg.op),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_hash  (result.hash_value)
);
